FILE: hw/rtl/binary_min_heap_queue_unit_assert.svh
// Assertion macros for the heap queue RTL.
// Depends on nothing; included by bmhq_ctrl, the only module that carries concurrent checks.
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BMHQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

FILE: hw/rtl/bmhq_pkg.sv
// Types and constants of the binary min-heap queue.
// Used by the datapath, the controller and the top level; depends on nothing.
package bmhq_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam int unsigned COUNT_W = 10;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] frequency;
        logic        leaf_flag;
        logic [7:0]  symbol;
        logic [9:0]  node_ref;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_frequency;
        logic               out_leaf_flag;
        logic [7:0]         out_symbol;
        logic [9:0]         out_node_ref;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] freq;
        logic        leaf;
        logic [7:0]  sym;
        logic [9:0]  node_ref;
    } t_entry;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ROOT_LAST,
        RD_PARENT,
        RD_CHILDREN
    } t_rd_sel;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH_START,
        ACT_POP_CAP,
        ACT_UP_STEP,
        ACT_DOWN_STEP,
        ACT_PLACE
    } t_act;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_RD_A,
        SRC_RES
    } t_src;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        t_act    act;
        logic    emit;
        t_status emit_status;
        t_src    emit_src;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       up_more;
        logic       down_more;
        logic       up_swap;
        logic       down_swap;
    } t_dp_sts;

endpackage

FILE: hw/rtl/binary_min_heap_queue_unit.sv
// Top level of the binary min-heap priority queue.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath.
//
// This unit keeps up to CAPACITY entries in an array-based binary min-heap keyed
// on frequency, as used when building Huffman trees. A request is taken at a rising
// edge where start is high and busy is low; busy then stays high until the result
// is produced. The result appears on o_rsp for exactly one cycle, marked by o_done,
// and the receiver has no way to hold it off, so it must capture it in that cycle.
// A push appends the entry and sifts it up; a pop returns the root, moves the last
// entry to the root and sifts it down, preferring the left child on a tie; a peek
// returns the root and leaves the heap alone. Popping or peeking an empty heap
// reports status 1, pushing into a full heap reports status 2, and in those cases
// and on every push the returned entry fields are zero. entry_count always gives
// the fill after the request, modulo 1024. Timing is set by the single entry
// memory: each heap level is read in S_UP_CHK or S_DOWN_CHK (the parent on a
// push, both children on a pop through two read ports), then compared and written
// back in S_UP_CMP or S_DOWN_CMP. A rejected or unused request is answered from
// S_DISPATCH and a peek from S_POP_CAP. The entry memory needs no clearing after
// reset, so the first request may be issued right after reset is released.
module binary_min_heap_queue_unit #(
    parameter int unsigned CAPACITY = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bmhq_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output bmhq_pkg::t_rsp o_rsp
);

    // Command and status link between the sequencer and the datapath.
    bmhq_pkg::t_dp_cmd w_cmd;
    bmhq_pkg::t_dp_sts w_sts;

    // The sequencer decides the next step from the datapath's compare results.
    bmhq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // The datapath owns the heap memory, the fill count and the result register.
    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: hw/rtl/bmhq_datapath.sv
// Datapath of the heap queue: entry memory, fill count, sift registers, result register.
// Depends on bmhq_pkg; driven by bmhq_ctrl through command and status structs.
module bmhq_datapath #(
    parameter int unsigned CAPACITY = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmhq_pkg::t_req    i_req,
    input  bmhq_pkg::t_dp_cmd i_cmd,
    output bmhq_pkg::t_dp_sts o_sts,
    output bmhq_pkg::t_rsp    o_rsp
);

    localparam int unsigned AW = $clog2(CAPACITY + 1);

    // Slot 0 is unused; valid entries sit in slots 1 to r_fill.
    bmhq_pkg::t_entry r_mem [0:CAPACITY];

    logic [1:0]       r_op;
    bmhq_pkg::t_entry r_item;
    bmhq_pkg::t_entry r_res;
    bmhq_pkg::t_entry r_rd_a;
    bmhq_pkg::t_entry r_rd_b;
    bmhq_pkg::t_rsp   r_rsp;
    logic [AW-1:0]    r_fill;
    logic [AW-1:0]    r_pos;

    logic [AW:0]      w_left;
    logic [AW:0]      w_right;
    logic [AW:0]      w_fill_x;
    logic             w_right_ok;
    logic             w_right_pick;
    bmhq_pkg::t_entry w_chosen;
    logic [AW-1:0]    w_chosen_idx;
    logic [AW-1:0]    w_rd_addr_a;
    logic [AW-1:0]    w_rd_addr_b;
    logic             w_rd_en;
    logic             w_we;
    bmhq_pkg::t_entry w_wdata;
    bmhq_pkg::t_entry w_emit_entry;
    logic [31:0]      w_fill_wide;

    assign w_left       = {r_pos, 1'b0};
    assign w_right      = w_left + (AW + 1)'(1);
    assign w_fill_x     = {1'b0, r_fill};
    assign w_right_ok   = (w_right <= w_fill_x);
    // Left child wins ties; right only when strictly smaller.
    assign w_right_pick = w_right_ok && (r_rd_b.freq < r_rd_a.freq);
    assign w_chosen     = w_right_pick ? r_rd_b : r_rd_a;
    assign w_chosen_idx = w_right_pick ? w_right[AW-1:0] : w_left[AW-1:0];

    assign o_sts.op        = r_op;
    assign o_sts.empty     = (r_fill == '0);
    assign o_sts.full      = (r_fill >= AW'(CAPACITY));
    assign o_sts.up_more   = (r_pos >= AW'(2));
    assign o_sts.down_more = (w_left <= w_fill_x);
    assign o_sts.up_swap   = (r_rd_a.freq > r_item.freq);
    assign o_sts.down_swap = (r_item.freq > w_chosen.freq);

    always_comb begin
        w_rd_en     = 1'b1;
        w_rd_addr_a = '0;
        w_rd_addr_b = '0;
        case (i_cmd.rd_sel)
            bmhq_pkg::RD_ROOT_LAST: begin
                w_rd_addr_a = AW'(1);
                w_rd_addr_b = r_fill;
            end
            bmhq_pkg::RD_PARENT: begin
                w_rd_addr_a = r_pos >> 1;
                w_rd_addr_b = r_pos >> 1;
            end
            bmhq_pkg::RD_CHILDREN: begin
                w_rd_addr_a = w_left[AW-1:0];
                w_rd_addr_b = w_right_ok ? w_right[AW-1:0] : w_left[AW-1:0];
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_item;
        case (i_cmd.act)
            bmhq_pkg::ACT_UP_STEP: begin
                w_we    = 1'b1;
                w_wdata = r_rd_a;
            end
            bmhq_pkg::ACT_DOWN_STEP: begin
                w_we    = 1'b1;
                w_wdata = w_chosen;
            end
            bmhq_pkg::ACT_PLACE: begin
                w_we    = 1'b1;
                w_wdata = r_item;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.emit_src)
            bmhq_pkg::SRC_RD_A: w_emit_entry = r_rd_a;
            bmhq_pkg::SRC_RES:  w_emit_entry = r_res;
            default:            w_emit_entry = '0;
        endcase
    end

    assign w_fill_wide = 32'(r_fill);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            case (i_cmd.act)
                bmhq_pkg::ACT_PUSH_START: r_fill <= r_fill + AW'(1);
                bmhq_pkg::ACT_POP_CAP:    r_fill <= r_fill - AW'(1);
                default:                  r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op          <= i_req.operation;
            r_item.freq     <= i_req.frequency;
            r_item.leaf     <= i_req.leaf_flag;
            r_item.sym      <= i_req.symbol;
            r_item.node_ref <= i_req.node_ref;
        end
        case (i_cmd.act)
            bmhq_pkg::ACT_PUSH_START: r_pos <= r_fill + AW'(1);
            bmhq_pkg::ACT_POP_CAP: begin
                r_res  <= r_rd_a;
                r_item <= r_rd_b;
                r_pos  <= AW'(1);
            end
            bmhq_pkg::ACT_UP_STEP:   r_pos <= r_pos >> 1;
            bmhq_pkg::ACT_DOWN_STEP: r_pos <= w_chosen_idx;
            default:                 r_pos <= r_pos;
        endcase
        if (i_cmd.emit) begin
            r_rsp.status        <= i_cmd.emit_status;
            r_rsp.out_frequency <= w_emit_entry.freq;
            r_rsp.out_leaf_flag <= w_emit_entry.leaf;
            r_rsp.out_symbol    <= w_emit_entry.sym;
            r_rsp.out_node_ref  <= w_emit_entry.node_ref;
            r_rsp.entry_count   <= w_fill_wide[bmhq_pkg::COUNT_W-1:0];
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: hw/rtl/bmhq_ctrl.sv
// Controller state machine of the heap queue: sequences reads, compares and writes.
// Depends on bmhq_pkg and binary_min_heap_queue_unit_assert.svh; drives bmhq_datapath.
`include "binary_min_heap_queue_unit_assert.svh"

module bmhq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bmhq_pkg::t_dp_sts i_sts,
    output bmhq_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_CAP,
        S_UP_CHK,
        S_UP_CMP,
        S_DOWN_CHK,
        S_DOWN_CMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state           = r_state;
        n_done            = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.rd_sel      = bmhq_pkg::RD_NONE;
        o_cmd.act         = bmhq_pkg::ACT_NONE;
        o_cmd.emit        = 1'b0;
        o_cmd.emit_status = bmhq_pkg::ST_OK;
        o_cmd.emit_src    = bmhq_pkg::SRC_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    bmhq_pkg::OP_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = bmhq_pkg::ST_FULL;
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.act = bmhq_pkg::ACT_PUSH_START;
                            n_state   = S_UP_CHK;
                        end
                    end
                    bmhq_pkg::OP_POP, bmhq_pkg::OP_PEEK: begin
                        if (i_sts.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = bmhq_pkg::ST_EMPTY;
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.rd_sel = bmhq_pkg::RD_ROOT_LAST;
                            n_state      = S_POP_CAP;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        n_done     = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_POP_CAP: begin
                if (i_sts.op == bmhq_pkg::OP_PEEK) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = bmhq_pkg::SRC_RD_A;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.act = bmhq_pkg::ACT_POP_CAP;
                    n_state   = S_DOWN_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_sts.up_more) begin
                    o_cmd.rd_sel = bmhq_pkg::RD_PARENT;
                    n_state      = S_UP_CMP;
                end else begin
                    o_cmd.act  = bmhq_pkg::ACT_PLACE;
                    o_cmd.emit = 1'b1;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_swap) begin
                    o_cmd.act = bmhq_pkg::ACT_UP_STEP;
                    n_state   = S_UP_CHK;
                end else begin
                    o_cmd.act  = bmhq_pkg::ACT_PLACE;
                    o_cmd.emit = 1'b1;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DOWN_CHK: begin
                if (i_sts.down_more) begin
                    o_cmd.rd_sel = bmhq_pkg::RD_CHILDREN;
                    n_state      = S_DOWN_CMP;
                end else begin
                    o_cmd.act      = bmhq_pkg::ACT_PLACE;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = bmhq_pkg::SRC_RES;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DOWN_CMP: begin
                if (i_sts.down_swap) begin
                    o_cmd.act = bmhq_pkg::ACT_DOWN_STEP;
                    n_state   = S_DOWN_CHK;
                end else begin
                    o_cmd.act      = bmhq_pkg::ACT_PLACE;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = bmhq_pkg::SRC_RES;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    // A result only appears once the sequencer is back at rest.
    `BMHQ_ASSERT_SAME(a_done_at_rest, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    // An accepted request always moves on to dispatch.
    `BMHQ_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_start && !o_busy, r_state == S_DISPATCH)
    // One request never yields two results in a row.
    `BMHQ_ASSERT_NEXT(a_single_done, i_clk, i_rst_n, r_done, !r_done)
    // The result register is never loaded while a memory read is issued.
    `BMHQ_ASSERT_SAME(a_emit_no_read, i_clk, i_rst_n, o_cmd.emit, o_cmd.rd_sel == bmhq_pkg::RD_NONE)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_queue_unit.
// Depends on bmhq_pkg and the heap queue RTL; holds its own heap predictor and scoreboard.

module tb_top;

    // The heap depth is shared by the block and by the predictor below.
    localparam int unsigned HEAP_DEPTH = 512;

    // Operation code 3 has no meaning in the package. The block must treat it as a no-op
    // that still answers with the current fill.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // The predictor mirrors the heap array. Slot 0 is unused and live entries sit in
    // slots 1..entries. Every accepted request is folded into this copy as soon as the
    // handshake completes, and the response it should produce is queued in order.
    class heap_response_board;
        bmhq_pkg::t_entry heap_mem [0:HEAP_DEPTH];
        int unsigned      entries;
        bmhq_pkg::t_rsp   awaited_rsps [$];
        int unsigned      mismatches;
        int unsigned      strays;
        int unsigned      checked;
        int unsigned      op_seen [4];
        int unsigned      deepest;
        int unsigned      full_rejects;
        int unsigned      empty_rejects;

        function new();
            entries = 0;
            mismatches = 0;
            strays = 0;
            checked = 0;
            deepest = 0;
            full_rejects = 0;
            empty_rejects = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function void note_request(bmhq_pkg::t_req req);
            bmhq_pkg::t_rsp   want;
            bmhq_pkg::t_entry held;
            int unsigned      pos;
            int unsigned      kid;
            want = '0;
            op_seen[req.operation]++;
            case (req.operation)
                bmhq_pkg::OP_PUSH: begin
                    if (entries >= HEAP_DEPTH) begin
                        want.status = bmhq_pkg::ST_FULL;
                        full_rejects++;
                    end else begin
                        entries++;
                        heap_mem[entries] = '{freq: req.frequency, leaf: req.leaf_flag,
                                              sym: req.symbol, node_ref: req.node_ref};
                        // Sift up while the parent key is strictly larger.
                        pos = entries;
                        while (pos >= 2 && heap_mem[pos / 2].freq > heap_mem[pos].freq) begin
                            held = heap_mem[pos / 2];
                            heap_mem[pos / 2] = heap_mem[pos];
                            heap_mem[pos] = held;
                            pos = pos / 2;
                        end
                    end
                end
                bmhq_pkg::OP_POP, bmhq_pkg::OP_PEEK: begin
                    if (entries == 0) begin
                        want.status = bmhq_pkg::ST_EMPTY;
                        empty_rejects++;
                    end else begin
                        want.out_frequency = heap_mem[1].freq;
                        want.out_leaf_flag = heap_mem[1].leaf;
                        want.out_symbol    = heap_mem[1].sym;
                        want.out_node_ref  = heap_mem[1].node_ref;
                        if (req.operation == bmhq_pkg::OP_POP) begin
                            heap_mem[1] = heap_mem[entries];
                            entries--;
                            // Sift down: the right child wins only when strictly smaller,
                            // and an equal key stops the walk.
                            pos = 1;
                            while (2 * pos <= entries) begin
                                kid = 2 * pos;
                                if (kid + 1 <= entries &&
                                    heap_mem[kid + 1].freq < heap_mem[kid].freq) begin
                                    kid++;
                                end
                                if (heap_mem[pos].freq <= heap_mem[kid].freq) break;
                                held = heap_mem[pos];
                                heap_mem[pos] = heap_mem[kid];
                                heap_mem[kid] = held;
                                pos = kid;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            want.entry_count = entries[bmhq_pkg::COUNT_W-1:0];
            if (entries > deepest) deepest = entries;
            awaited_rsps = {awaited_rsps, want};
        endfunction

        function void check_response(bmhq_pkg::t_rsp got);
            bmhq_pkg::t_rsp want;
            if (awaited_rsps.size() == 0) begin
                strays++;
                if (mismatches + strays <= 10) begin
                    $display("unexpected response: st=%0d f=%h l=%0d s=%h r=%h n=%0d",
                             got.status, got.out_frequency, got.out_leaf_flag,
                             got.out_symbol, got.out_node_ref, got.entry_count);
                end
                return;
            end
            want = awaited_rsps.pop_front();
            checked++;
            if (got.status !== want.status || got.out_frequency !== want.out_frequency ||
                got.out_leaf_flag !== want.out_leaf_flag ||
                got.out_symbol !== want.out_symbol ||
                got.out_node_ref !== want.out_node_ref ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches + strays <= 10) begin
                    $display("response %0d: expected st=%0d f=%h l=%0d s=%h r=%h n=%0d",
                             checked, want.status, want.out_frequency, want.out_leaf_flag,
                             want.out_symbol, want.out_node_ref, want.entry_count);
                    $display("response %0d:   actual st=%0d f=%h l=%0d s=%h r=%h n=%0d",
                             checked, got.status, got.out_frequency, got.out_leaf_flag,
                             got.out_symbol, got.out_node_ref, got.entry_count);
                end
            end
        endfunction
    endclass

    // Every input is known from time zero; reset is held low from the very start.
    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    bmhq_pkg::t_req i_req   = '0;
    logic           busy;
    logic           o_done;
    bmhq_pkg::t_rsp o_rsp;

    heap_response_board board = new();

    binary_min_heap_queue_unit #(
        .CAPACITY(HEAP_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The result strobe lasts a single cycle and cannot be held off, so every rising
    // edge with o_done high carries exactly one response that must be checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_response(o_rsp);
        end
    end

    function automatic bmhq_pkg::t_req make_req(logic [1:0] op, logic [31:0] freq,
                                                logic leaf, logic [7:0] sym,
                                                logic [9:0] handle);
        bmhq_pkg::t_req req;
        req.operation = op;
        req.frequency = freq;
        req.leaf_flag = leaf;
        req.symbol    = sym;
        req.node_ref  = handle;
        return req;
    endfunction

    // Random request. A narrow key range forces many equal keys, which is where the
    // tie and stop rules of the sift show up; a wide range exercises every key bit.
    // Pops and peeks also carry random payload bits that the block must ignore.
    function automatic bmhq_pkg::t_req random_request(int unsigned push_pct, bit narrow_keys);
        bmhq_pkg::t_req req;
        int unsigned    roll;
        roll = $urandom_range(99);
        if (roll < push_pct) begin
            req.operation = bmhq_pkg::OP_PUSH;
        end else if (roll >= 97) begin
            req.operation = OP_UNUSED;
        end else if ($urandom_range(3) == 0) begin
            req.operation = bmhq_pkg::OP_PEEK;
        end else begin
            req.operation = bmhq_pkg::OP_POP;
        end
        if (!narrow_keys) begin
            req.frequency = $urandom();
        end else if ($urandom_range(7) == 0) begin
            req.frequency = 32'hFFFF_FFF0 | 32'($urandom_range(15));
        end else begin
            req.frequency = 32'($urandom_range(15));
        end
        req.leaf_flag = 1'($urandom_range(1));
        req.symbol    = 8'($urandom());
        req.node_ref  = 10'($urandom());
        return req;
    endfunction

    // Present a request at the falling edge and hold it until a rising edge sees busy
    // low. start is left high on return so that a back-to-back request does not
    // lower and raise it within one time step.
    task automatic send_request(input bmhq_pkg::t_req req);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(req);
    endtask

    // Random sender idling between requests: each idle cycle is taken with the given
    // chance, so gaps land on every phase of the block's sift work.
    task automatic sender_gap(input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= random_request(50, 1'b0);
            @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned idle_pct;
        int unsigned push_pct;
        bit          narrow;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-heap rejects, the unused code, payload extremes, and the
        // two sift rules. With keys 1, 5, 5, 9 a pop moves 9 to the root over two equal
        // children, and the left one must win. Two equal keys later check that the
        // sift up stops when the parent equals the child.
        send_request(make_req(bmhq_pkg::OP_PEEK, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_POP, 32'hFFFF_FFFF, 1'b1, 8'hFF, 10'h3FF));
        send_request(make_req(OP_UNUSED, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1, 8'hFF, 10'h3FF));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_PEEK, 32'hFFFF_FFFF, 1'b1, 8'hFF, 10'h3FF));
        send_request(make_req(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 8'hFF, 10'h3FF));
        send_request(make_req(bmhq_pkg::OP_POP, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_POP, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'd1, 1'b1, 8'h01, 10'h001));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'd5, 1'b0, 8'h0A, 10'h00A));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'd5, 1'b1, 8'h0B, 10'h00B));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'd9, 1'b0, 8'h0C, 10'h00C));
        repeat (4) send_request(make_req(bmhq_pkg::OP_POP, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'd7, 1'b0, 8'h21, 10'h121));
        send_request(make_req(bmhq_pkg::OP_PUSH, 32'd7, 1'b1, 8'h22, 10'h222));
        send_request(make_req(bmhq_pkg::OP_POP, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_POP, 32'h0, 1'b0, 8'h00, 10'h000));
        send_request(make_req(bmhq_pkg::OP_PEEK, 32'h0, 1'b0, 8'h00, 10'h000));

        // Fill the heap to capacity and knock on it while full. This reaches the
        // deepest sift paths and the largest entry count; the random part below then
        // starts from a full heap.
        while (board.entries < HEAP_DEPTH) begin
            sender_gap(19);
            send_request(random_request(100, $urandom_range(1) == 0));
        end
        repeat (2) send_request(random_request(100, 1'b0));
        send_request(make_req(bmhq_pkg::OP_PEEK, 32'h0, 1'b0, 8'h00, 10'h000));

        // Random part in three idling phases: none, heavy and light. The receiver
        // cannot stall, so only the sender idles. Within a phase the mix is drawn anew for
        // each of three stretches of 8 requests, so the heap may grow, hover or shrink.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 80 : 19;
            for (int stretch = 0; stretch < 3; stretch++) begin
                case ($urandom_range(2))
                    0: push_pct = 75;
                    1: push_pct = 50;
                    default: push_pct = 25;
                endcase
                narrow = 1'($urandom_range(1));
                repeat (8) begin
                    sender_gap(idle_pct);
                    send_request(random_request(push_pct, narrow));
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;

        // Wait for every queued response, then a little longer than the slowest
        // request so that any stray strobe is still caught.
        while (board.awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d pushes, %0d pops, %0d peeks and %0d unused requests.",
                 board.op_seen[bmhq_pkg::OP_PUSH], board.op_seen[bmhq_pkg::OP_POP],
                 board.op_seen[bmhq_pkg::OP_PEEK], board.op_seen[OP_UNUSED]);
        $display("Deepest fill %0d, %0d full and %0d empty rejects, %0d responses checked.",
                 board.deepest, board.full_rejects, board.empty_rejects, board.checked);
        if (board.mismatches == 0 && board.strays == 0 &&
            board.awaited_rsps.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d unexpected responses, %0d still awaited.",
                     board.mismatches, board.strays, board.awaited_rsps.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #10ms;
        $display("Timeout with %0d responses still awaited.", board.awaited_rsps.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
